[rtl/sdf_pkg.sv]
package sdf_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_WIDTH = 17;
	localparam int CFG_WIDTH = 32;
	localparam int CFG_IDX_WIDTH = 2;
	localparam int SPEED_WIDTH = 31;

	localparam logic [CFG_WIDTH-1:0] SMOOTH_TIME_RST = 32'd19661;
	localparam logic [SPEED_WIDTH-1:0] LIMIT_RST = 31'h7FFF_FFFF;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_SMOOTH_TIME  = 2'd0,
		REG_MAX_SPEED    = 2'd1,
		REG_MAX_DISTANCE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		AOP_MUL,
		AOP_DIV,
		AOP_SQRT
	} aop_t;

	typedef struct packed {
		logic start;
		aop_t op;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	typedef struct packed {
		logic                           action;
		logic signed [VALUE_WIDTH-1:0]  target_x;
		logic signed [VALUE_WIDTH-1:0]  target_y;
		logic signed [VALUE_WIDTH-1:0]  target_z;
		logic [DT_WIDTH-1:0]            time_step;
	} req_word_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0]  pos_x;
		logic signed [VALUE_WIDTH-1:0]  pos_y;
		logic signed [VALUE_WIDTH-1:0]  pos_z;
		logic signed [VALUE_WIDTH-1:0]  vel_x;
		logic signed [VALUE_WIDTH-1:0]  vel_y;
		logic signed [VALUE_WIDTH-1:0]  vel_z;
		logic                           snapped;
		logic                           distance_limited;
	} rsp_word_t;

endpackage

[rtl/sdf_arith.sv]
module sdf_arith #(
	parameter int MW = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sdf_pkg::arith_req_t   req,
	input  logic [MW-1:0]         opnd_a,
	input  logic [MW-1:0]         opnd_b,
	input  logic [2*MW-1:0]       num,
	output sdf_pkg::arith_sts_t   sts,
	output logic [2*MW-1:0]       res
);
	import sdf_pkg::*;

	localparam int PW = 2 * MW;
	localparam int CW = $clog2(PW + 1);

	aop_t            op_q;
	logic [MW-1:0]   a_q;
	logic [MW-1:0]   b_q;
	logic [MW+1:0]   rem_q;
	logic [PW-1:0]   work_q;
	logic [MW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [MW:0]     mul_sum;
	logic [MW:0]     div_rem2;
	logic [MW+1:0]   div_diff;
	logic            div_ge;
	logic [MW+3:0]   sq_rem2;
	logic [MW+3:0]   sq_trial;
	logic [MW+4:0]   sq_diff;
	logic            sq_ge;

	always_comb begin
		mul_sum  = {1'b0, rem_q[MW-1:0]} + (work_q[0] ? {1'b0, a_q} : '0);
		div_rem2 = {rem_q[MW-1:0], work_q[PW-1]};
		div_diff = {1'b0, div_rem2} - {2'b00, b_q};
		div_ge   = !div_diff[MW+1];
		sq_rem2  = {rem_q, work_q[PW-1 -: 2]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_diff  = {1'b0, sq_rem2} - {1'b0, sq_trial};
		sq_ge    = !sq_diff[MW+4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= AOP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				a_q    <= opnd_a;
				b_q    <= opnd_b;
				rem_q  <= '0;
				root_q <= '0;
				busy_q <= 1'b1;
				unique case (req.op)
					AOP_MUL: begin
						work_q <= {{MW{1'b0}}, opnd_b};
						cnt_q  <= CW'(MW);
					end
					AOP_DIV: begin
						work_q <= num;
						cnt_q  <= CW'(PW);
					end
					default: begin
						work_q <= num;
						cnt_q  <= CW'(MW);
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				unique case (op_q)
					AOP_MUL: begin
						rem_q  <= {2'b00, mul_sum[MW:1]};
						work_q <= {work_q[PW-1:MW], mul_sum[0], work_q[MW-1:1]};
					end
					AOP_DIV: begin
						rem_q  <= div_ge ? {1'b0, div_diff[MW:0]} : {1'b0, div_rem2};
						work_q <= {work_q[PW-2:0], div_ge};
					end
					default: begin
						rem_q  <= sq_ge ? sq_diff[MW+1:0] : sq_rem2[MW+1:0];
						root_q <= {root_q[MW-2:0], sq_ge};
						work_q <= {work_q[PW-3:0], 2'b00};
					end
				endcase
			end
		end
	end

	always_comb begin
		unique case (op_q)
			AOP_MUL:  res = {rem_q[MW-1:0], work_q[MW-1:0]};
			AOP_DIV:  res = work_q;
			default:  res = {{MW{1'b0}}, root_q};
		endcase
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

[rtl/smooth_damp_follower_3d_core.sv]
// Critically damped 3D follower. A word on the req channel carries a target point,
// a time step and an action; each accepted word gives exactly one word on the rsp
// channel with the new position, velocity and two flags. Both channels use valid
// and stall; a word moves at a clock edge with valid high and stall low.
// Configuration registers (smoothing time, speed limit, distance limit) are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Every operation runs on
// one shared bit-serial unit (multiply, divide, square root) of operand width MW,
// with MW = 42 at the default widths. A step item runs extra scaling steps when the
// offset or distance has to be clamped; a load item goes straight to the final step.
// req_stall is high from acceptance until the result has been placed in the
// output register; the next word is accepted while that result still waits.
// When the receiver stalls, the finished result is held and the block waits with
// its next result until the output register is free.
// Reset clears position and velocity to zero and sets the registers to their
// default values; no result is pending after reset.
module smooth_damp_follower_3d_core #(
	parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  sdf_pkg::req_word_t                  req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output sdf_pkg::rsp_word_t                  rsp,
	input  logic                                cfg_we,
	input  logic [sdf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [sdf_pkg::CFG_WIDTH-1:0]       cfg_data
);
	import sdf_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int Q    = FRAC_BITS;
	localparam int VW   = W + 5;
	localparam int VX   = VW + 1;
	localparam int MW_A = (W + 5 > Q + 26) ? W + 5 : Q + 26;
	localparam int MW   = (MW_A > 2 * Q + 2) ? MW_A : 2 * Q + 2;
	localparam int PW   = 2 * MW;

	localparam longint ONE_L = longint'(1) << Q;
	localparam longint WMAX_L = (longint'(1) << (W + 3)) - 1;
	localparam logic [CFG_WIDTH-1:0] ST_MIN = CFG_WIDTH'((ONE_L + 9999) / 10000);
	localparam logic [MW-1:0] K048  = MW'((48 * ONE_L + 50) / 100);
	localparam logic [MW-1:0] K0235 = MW'((235 * ONE_L + 500) / 1000);
	localparam logic [MW-1:0] ONE_M = MW'(ONE_L);
	localparam logic [MW-1:0] X_CAP = MW'(1) << (Q + 8);
	localparam logic [PW-1:0] NUM_OMEGA = PW'(1) << (2 * Q + 1);
	localparam logic [PW-1:0] NUM_D = PW'(1) << (2 * Q);
	localparam logic signed [VW-1:0] WMAX = VW'(WMAX_L);
	localparam logic signed [VX-1:0] WMAX_X = VX'(WMAX_L);
	localparam logic [PW-1:0] WMAX_P = PW'(WMAX_L);
	localparam logic signed [VW-1:0] VMAX_V = VW'((longint'(1) << (W - 1)) - 1);
	localparam logic signed [VW-1:0] VMIN_V = VW'(-(longint'(1) << (W - 1)));
	localparam logic [1:0] AX_LAST = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_OMEGA, S_X, S_X2, S_X3, S_K2, S_K3, S_DEN, S_MLEN, S_VEC,
		S_SQ, S_LEN, S_SCMUL, S_SCDIV, S_A1, S_T, S_A2, S_NV, S_P4, S_OV,
		S_SNAP, S_FIN
	} state_t;

	function automatic logic signed [VW-1:0] f_sadd(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		logic signed [VX-1:0] s;
		logic signed [VW-1:0] r;
		s = VX'(a) + VX'(b);
		if (s > WMAX_X)
			r = WMAX;
		else if (s < -WMAX_X)
			r = -WMAX;
		else
			r = VW'(s);
		return r;
	endfunction

	function automatic logic [MW-1:0] f_mag(input logic signed [VW-1:0] v);
		logic [VW-1:0] m;
		m = v[VW-1] ? VW'(-v) : VW'(v);
		return MW'(m);
	endfunction

	function automatic logic signed [VW-1:0] f_smul(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] sh;
		logic signed [VW-1:0] m;
		sh = p >> Q;
		m = (sh > WMAX_P) ? WMAX : $signed(VW'(sh));
		return neg ? -m : m;
	endfunction

	function automatic logic signed [W-1:0] f_sat(input logic signed [VW-1:0] v);
		logic signed [W-1:0] r;
		if (v > VMAX_V)
			r = W'(VMAX_V);
		else if (v < VMIN_V)
			r = W'(VMIN_V);
		else
			r = W'(v);
		return r;
	endfunction

	state_t                      state_q;
	logic                        go_q;
	logic                        pass_q;
	logic                        snapped_q;
	logic                        limited_q;
	logic [1:0]                  ax_q;
	logic signed [W-1:0]         pos_q [3];
	logic signed [W-1:0]         vel_q [3];
	logic signed [W-1:0]         tgt_q [3];
	logic [DT_WIDTH-1:0]         dt_q;
	logic [CFG_WIDTH-1:0]        st_q;
	logic [CFG_WIDTH-1:0]        smooth_time_q;
	logic [SPEED_WIDTH-1:0]      max_speed_q;
	logic [SPEED_WIDTH-1:0]      max_distance_q;
	logic [MW-1:0]               omega_q;
	logic [MW-1:0]               x_q;
	logic [MW-1:0]               x2_q;
	logic [MW-1:0]               x3_q;
	logic [MW-1:0]               den_q;
	logic [MW-1:0]               d_q;
	logic [MW-1:0]               maxlen_q;
	logic [MW-1:0]               len_q;
	logic signed [VW-1:0]        v_q [3];
	logic signed [VW-1:0]        p4_q [3];
	logic signed [VW-1:0]        nv_q [3];
	logic signed [VW-1:0]        w_q;
	logic signed [VW-1:0]        t_q;
	logic [PW-1:0]               acc_q;
	logic [PW-1:0]               prod_q;
	logic signed [PW+1:0]        ov_q;
	logic                        rsp_valid_q;
	rsp_word_t                   rsp_q;

	logic signed [VW-1:0]        v_ax;
	logic signed [VW-1:0]        pos_ax;
	logic signed [VW-1:0]        vel_ax;
	logic signed [VW-1:0]        tgt_ax;
	logic signed [VW-1:0]        s3;
	logic signed [VW-1:0]        ov_a;
	logic signed [VW-1:0]        ov_b;
	logic [MW-1:0]               lim;
	logic                        is_op;
	logic                        start;
	logic                        fin_ok;
	aop_t                        aop;
	logic [MW-1:0]               opa;
	logic [MW-1:0]               opb;
	logic [PW-1:0]               num;
	arith_req_t                  areq;
	arith_sts_t                  asts;
	logic [PW-1:0]               res;
	logic [PW-1:0]               sh;
	logic [MW-1:0]               res_m;
	logic signed [W-1:0]         pos_n [3];
	logic signed [W-1:0]         vel_n [3];

	always_comb begin
		v_ax   = v_q[ax_q];
		pos_ax = VW'(pos_q[ax_q]);
		vel_ax = VW'(vel_q[ax_q]);
		tgt_ax = VW'(tgt_q[ax_q]);
		s3     = f_sadd(v_ax, t_q);
		ov_a   = tgt_ax - pos_ax;
		ov_b   = p4_q[ax_q] - tgt_ax;
		lim    = pass_q ? MW'(max_distance_q) : maxlen_q;
		sh     = res >> Q;
		res_m  = res[MW-1:0];
		fin_ok = !rsp_valid_q || !rsp_stall;
		for (int i = 0; i < 3; i++) begin
			pos_n[i] = limited_q ? f_sat(f_sadd(VW'(tgt_q[i]), v_q[i])) : f_sat(p4_q[i]);
			vel_n[i] = f_sat(nv_q[i]);
		end
	end

	always_comb begin
		is_op = 1'b1;
		aop   = AOP_MUL;
		opa   = '0;
		opb   = '0;
		num   = '0;
		unique case (state_q)
			S_OMEGA: begin
				aop = AOP_DIV;
				num = NUM_OMEGA;
				opb = MW'(st_q);
			end
			S_X: begin
				opa = omega_q;
				opb = MW'(dt_q);
			end
			S_X2: begin
				opa = x_q;
				opb = x_q;
			end
			S_X3: begin
				opa = x2_q;
				opb = x_q;
			end
			S_K2: begin
				opa = K048;
				opb = x2_q;
			end
			S_K3: begin
				opa = K0235;
				opb = x3_q;
			end
			S_DEN: begin
				aop = AOP_DIV;
				num = NUM_D;
				opb = den_q;
			end
			S_MLEN: begin
				opa = MW'(max_speed_q);
				opb = MW'(st_q);
			end
			S_SQ: begin
				opa = f_mag(v_ax);
				opb = f_mag(v_ax);
			end
			S_LEN: begin
				aop = AOP_SQRT;
				num = acc_q;
			end
			S_SCMUL: begin
				opa = f_mag(v_ax);
				opb = lim;
			end
			S_SCDIV: begin
				aop = AOP_DIV;
				num = prod_q;
				opb = len_q;
			end
			S_A1: begin
				opa = omega_q;
				opb = f_mag(v_ax);
			end
			S_T: begin
				opa = f_mag(w_q);
				opb = MW'(dt_q);
			end
			S_A2: begin
				opa = omega_q;
				opb = f_mag(t_q);
			end
			S_NV: begin
				opa = f_mag(w_q);
				opb = d_q;
			end
			S_P4: begin
				opa = f_mag(s3);
				opb = d_q;
			end
			S_OV: begin
				opa = f_mag(ov_a);
				opb = f_mag(ov_b);
			end
			default: is_op = 1'b0;
		endcase
		start = is_op && !go_q;
	end

	assign areq.start = start;
	assign areq.op    = aop;

	sdf_arith #(
		.MW(MW)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.opnd_a (opa),
		.opnd_b (opb),
		.num    (num),
		.sts    (asts),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_time_q  <= SMOOTH_TIME_RST;
			max_speed_q    <= LIMIT_RST;
			max_distance_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SMOOTH_TIME:  smooth_time_q  <= cfg_data;
				REG_MAX_SPEED:    max_speed_q    <= cfg_data[SPEED_WIDTH-1:0];
				REG_MAX_DISTANCE: max_distance_q <= cfg_data[SPEED_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			pass_q      <= 1'b0;
			snapped_q   <= 1'b0;
			limited_q   <= 1'b0;
			ax_q        <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (start)
				go_q <= 1'b1;
			if (asts.done)
				go_q <= 1'b0;
			if (rsp_valid_q && !rsp_stall && state_q != S_FIN)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						tgt_q[0]  <= req.target_x;
						tgt_q[1]  <= req.target_y;
						tgt_q[2]  <= req.target_z;
						dt_q      <= req.time_step;
						snapped_q <= 1'b0;
						limited_q <= 1'b0;
						pass_q    <= 1'b0;
						st_q      <= (smooth_time_q < ST_MIN) ? ST_MIN : smooth_time_q;
						if (req.action) begin
							p4_q[0] <= VW'(req.target_x);
							p4_q[1] <= VW'(req.target_y);
							p4_q[2] <= VW'(req.target_z);
							for (int i = 0; i < 3; i++)
								nv_q[i] <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_OMEGA;
						end
					end
				end
				S_OMEGA: if (asts.done) begin
					omega_q <= res_m;
					state_q <= S_X;
				end
				S_X: if (asts.done) begin
					x_q     <= (sh > PW'(X_CAP)) ? X_CAP : MW'(sh);
					state_q <= S_X2;
				end
				S_X2: if (asts.done) begin
					x2_q    <= MW'(sh);
					state_q <= S_X3;
				end
				S_X3: if (asts.done) begin
					x3_q    <= MW'(sh);
					state_q <= S_K2;
				end
				S_K2: if (asts.done) begin
					den_q   <= ONE_M + x_q + MW'(sh);
					state_q <= S_K3;
				end
				S_K3: if (asts.done) begin
					den_q   <= den_q + MW'(sh);
					state_q <= S_DEN;
				end
				S_DEN: if (asts.done) begin
					d_q     <= res_m;
					state_q <= S_MLEN;
				end
				S_MLEN: if (asts.done) begin
					maxlen_q <= (sh > WMAX_P) ? MW'(WMAX_P) : MW'(sh);
					state_q  <= S_VEC;
				end
				S_VEC: begin
					for (int i = 0; i < 3; i++)
						v_q[i] <= VW'(pos_q[i]) - VW'(tgt_q[i]);
					acc_q   <= '0;
					ax_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ: if (asts.done) begin
					acc_q <= acc_q + res;
					if (ax_q == AX_LAST) begin
						state_q <= S_LEN;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				S_LEN: if (asts.done) begin
					len_q <= res_m;
					ax_q  <= '0;
					if (res_m > lim)
						state_q <= S_SCMUL;
					else if (pass_q)
						state_q <= S_FIN;
					else
						state_q <= S_A1;
				end
				S_SCMUL: if (asts.done) begin
					prod_q  <= res;
					state_q <= S_SCDIV;
				end
				S_SCDIV: if (asts.done) begin
					v_q[ax_q] <= v_ax[VW-1] ? -$signed(VW'(res_m)) : $signed(VW'(res_m));
					if (ax_q == AX_LAST) begin
						ax_q <= '0;
						if (pass_q) begin
							limited_q <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_A1;
						end
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_SCMUL;
					end
				end
				S_A1: if (asts.done) begin
					w_q     <= f_sadd(vel_ax, f_smul(res, v_ax[VW-1]));
					state_q <= S_T;
				end
				S_T: if (asts.done) begin
					t_q     <= f_smul(res, w_q[VW-1]);
					state_q <= S_A2;
				end
				S_A2: if (asts.done) begin
					w_q     <= f_sadd(vel_ax, -f_smul(res, t_q[VW-1]));
					state_q <= S_NV;
				end
				S_NV: if (asts.done) begin
					nv_q[ax_q] <= f_smul(res, w_q[VW-1]);
					state_q    <= S_P4;
				end
				S_P4: if (asts.done) begin
					p4_q[ax_q] <= f_sadd(f_sadd(pos_ax, -v_ax), f_smul(res, s3[VW-1]));
					if (ax_q == AX_LAST) begin
						ax_q    <= '0;
						ov_q    <= '0;
						state_q <= S_OV;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_A1;
					end
				end
				S_OV: if (asts.done) begin
					if (ov_a[VW-1] != ov_b[VW-1])
						ov_q <= ov_q - $signed({2'b00, res});
					else
						ov_q <= ov_q + $signed({2'b00, res});
					if (ax_q == AX_LAST)
						state_q <= S_SNAP;
					else
						ax_q <= ax_q + 1'b1;
				end
				S_SNAP: begin
					if (ov_q > 0) begin
						snapped_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							p4_q[i] <= VW'(tgt_q[i]);
							nv_q[i] <= '0;
							v_q[i]  <= '0;
						end
					end else begin
						for (int i = 0; i < 3; i++)
							v_q[i] <= p4_q[i] - VW'(tgt_q[i]);
					end
					pass_q  <= 1'b1;
					acc_q   <= '0;
					ax_q    <= '0;
					state_q <= S_SQ;
				end
				S_FIN: if (fin_ok) begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= pos_n[i];
						vel_q[i] <= vel_n[i];
					end
					rsp_q.pos_x            <= pos_n[0];
					rsp_q.pos_y            <= pos_n[1];
					rsp_q.pos_z            <= pos_n[2];
					rsp_q.vel_x            <= vel_n[0];
					rsp_q.vel_y            <= vel_n[1];
					rsp_q.vel_z            <= vel_n[2];
					rsp_q.snapped          <= snapped_q;
					rsp_q.distance_limited <= limited_q;
					rsp_valid_q            <= 1'b1;
					state_q                <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !asts.busy)
		else $error("shared unit started while busy");

	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		asts.done |-> go_q)
		else $error("shared unit finished without a pending operation");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside the final step");

	a_snap_still: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.snapped) |-> (rsp.vel_x == '0 && rsp.vel_y == '0 && rsp.vel_z == '0))
		else $error("snapped result with nonzero velocity");

endmodule
